// ===== hw/rtl/itl_pkg.sv =====
// ---------------------------------------------------------------------------
// Interpolated table lookup: shared definitions
// Item codes, register indexes, field layout and reset values used by the
// lookup block and its testbench.
// ---------------------------------------------------------------------------
package itl_pkg;

   // Item kinds carried in tuser.
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRACTION_BITS = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TABLE_LENGTH  = 1'b1;
   localparam int unsigned CSR_DATA_WIDTH = 8;

   // Register reset values.
   localparam logic [3:0] FRACTION_BITS_RESET = 4'd14;
   localparam int unsigned TABLE_LENGTH_RESET = 65;

   // Field widths.
   localparam int unsigned FB_WIDTH    = 4;
   localparam int unsigned INDEX_WIDTH = 7;
   localparam int unsigned VALUE_WIDTH = 32;
   localparam int unsigned POS_WIDTH   = 32;
   localparam int unsigned FRAC_WIDTH  = 15;   // widest fraction: fraction_bits of 15
   localparam int unsigned DIFF_WIDTH  = VALUE_WIDTH + 1;
   localparam int unsigned PROD_WIDTH  = VALUE_WIDTH + FRAC_WIDTH + 1;

   // Request tdata layout, lowest bits first.
   localparam int unsigned IDX_LSB         = 0;
   localparam int unsigned VAL_LSB         = IDX_LSB + INDEX_WIDTH;
   localparam int unsigned POS_LSB         = VAL_LSB + VALUE_WIDTH;
   localparam int unsigned REQ_DATA_WIDTH  = 72;

endpackage

// ===== hw/rtl/interpolated_table_lookup_top.sv =====
// ---------------------------------------------------------------------------
// Interpolated table lookup
// Table of signed 32-bit entries with linear interpolation between
// neighboring entries at a signed fixed-point position.
// ---------------------------------------------------------------------------
// A write item (tuser low) stores one entry and returns nothing; a lookup item
// (tuser high) returns one value. The block takes one item every cycle unless
// every stage is full and the result is not taken: a lookup passes through
// the registered read of two copies of the table, a stage holding the product
// of the entry difference and the fraction, and a stage that scales, rounds
// toward zero and adds. Stages hand items forward independently, so empty
// stages keep req_tready high while a result waits. Entries must be written
// before they are read; there is no clearing pass after reset.
module interpolated_table_lookup_top #(
   parameter int unsigned TABLE_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // entry_index[6:0], entry_value[38:7], position[70:39]
   input  logic        req_tuser,   // op
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // value[31:0]
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_data
);

   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam int unsigned CW = (AW + 15 > 31) ? AW + 15 : 31;
   localparam logic [AW-1:0] LAST_RESET =
      AW'((itl_pkg::TABLE_LENGTH_RESET > TABLE_DEPTH) ? TABLE_DEPTH - 1
                                                      : itl_pkg::TABLE_LENGTH_RESET - 1);

   // Configuration.
   logic [3:0]    fb_ff, fb_in;
   logic [AW-1:0] last_ff, last_in, last_wr;

   // Request fields.
   logic                 op;
   logic [6:0]           entry_index;
   logic signed [31:0]   entry_value;
   logic signed [31:0]   position;
   logic                 accept;
   logic [31:0]          index_ext;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;

   // Address decode.
   logic [AW+14:0]       limit;
   logic                 below, beyond;
   logic [30:0]          idx_full;
   logic [AW-1:0]        addr_a, addr_b;
   logic [15:0]          frac_mask;
   logic [14:0]          frac;

   // Stage 1: table read.
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_clamp_ff;
   logic [14:0]          s1_frac_ff;
   logic [3:0]           s1_fb_ff;
   logic [31:0]          left_data, right_data;

   // Stage 2: product.
   logic                 s2_valid_ff, s2_valid_in;
   logic signed [31:0]   s2_left_ff;
   logic signed [47:0]   s2_prod_ff;
   logic [3:0]           s2_fb_ff;
   logic signed [32:0]   diff;
   logic signed [15:0]   frac_s;
   logic signed [48:0]   prod_full;

   // Stage 3: scale and add.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_data_ff;
   logic [47:0]          bias;
   logic signed [47:0]   prod_biased;
   logic signed [47:0]   quot;
   logic [31:0]          result;

   // Stage hand-off.
   logic                 out_free, s2_move, s1_move;

   assign op          = req_tuser;
   assign entry_index = req_tdata[itl_pkg::IDX_LSB +: itl_pkg::INDEX_WIDTH];
   assign entry_value = req_tdata[itl_pkg::VAL_LSB +: itl_pkg::VALUE_WIDTH];
   assign position    = req_tdata[itl_pkg::POS_LSB +: itl_pkg::POS_WIDTH];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s2_move    = !s2_valid_ff || out_free;
   assign s1_move    = !s1_valid_ff || s2_move;
   assign req_tready = s1_move;
   assign accept     = req_tvalid && s1_move;

   // ---------------- Configuration ----------------
   assign csr_ready = 1'b1;

   always_comb begin
      if (32'(csr_data) < 32'd2) begin
         last_wr = AW'(1);
      end else if (32'(csr_data) > TABLE_DEPTH) begin
         last_wr = AW'(TABLE_DEPTH - 1);
      end else begin
         last_wr = AW'(32'(csr_data) - 32'd1);
      end
   end

   always_comb begin
      fb_in   = fb_ff;
      last_in = last_ff;
      if (csr_valid) begin
         unique case (csr_index)
            itl_pkg::CSR_FRACTION_BITS: fb_in   = csr_data[3:0];
            itl_pkg::CSR_TABLE_LENGTH:  last_in = last_wr;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_ff   <= itl_pkg::FRACTION_BITS_RESET;
         last_ff <= LAST_RESET;
      end else begin
         fb_ff   <= fb_in;
         last_ff <= last_in;
      end
   end

   // ---------------- Table writes ----------------
   assign index_ext = 32'(entry_index);
   assign wr_en     = accept && (op == itl_pkg::OP_WRITE) && (index_ext < TABLE_DEPTH);
   assign wr_addr   = index_ext[AW-1:0];

   // ---------------- Address decode ----------------
   assign limit    = (AW+15)'(last_ff) << fb_ff;
   assign below    = position[31];
   assign beyond   = CW'(position[30:0]) >= CW'(limit);
   assign idx_full = position[30:0] >> fb_ff;
   assign frac_mask = (16'd1 << fb_ff) - 16'd1;

   always_comb begin
      addr_a = idx_full[AW-1:0];
      frac   = position[14:0] & frac_mask[14:0];
      if (below) begin
         addr_a = '0;
         frac   = '0;
      end else if (beyond) begin
         addr_a = last_ff;
         frac   = '0;
      end
   end

   assign addr_b = addr_a + AW'(1);

   // Two copies of the table give both neighbors in one read.
   itl_ram #(
      .WIDTH (32),
      .DEPTH (TABLE_DEPTH)
   ) u_ram_left (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (entry_value),
      .rd_en   (s1_move),
      .rd_addr (addr_a),
      .rd_data (left_data)
   );

   itl_ram #(
      .WIDTH (32),
      .DEPTH (TABLE_DEPTH)
   ) u_ram_right (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (entry_value),
      .rd_en   (s1_move),
      .rd_addr (addr_b),
      .rd_data (right_data)
   );

   // ---------------- Stage 1 -> 2 ----------------
   assign s1_valid_in = s1_move ? (accept && op == itl_pkg::OP_LOOKUP) : s1_valid_ff;

   // A clamped lookup must not depend on the right neighbor, which may be unwritten.
   assign diff      = s1_clamp_ff ? '0 : (33'(signed'(right_data)) - 33'(signed'(left_data)));
   assign frac_s    = signed'({1'b0, s1_frac_ff});
   assign prod_full = diff * frac_s;

   assign s2_valid_in = s2_move ? s1_valid_ff : s2_valid_ff;

   // ---------------- Stage 2 -> 3 ----------------
   // Negative products get a bias of 2^fb - 1 so the shift rounds toward zero.
   assign bias        = s2_prod_ff[47] ? ((48'd1 << s2_fb_ff) - 48'd1) : '0;
   assign prod_biased = s2_prod_ff + signed'(bias);
   assign quot        = prod_biased >>> s2_fb_ff;
   assign result      = s2_left_ff + quot[31:0];

   assign rsp_valid_in = out_free ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s1_clamp_ff <= below || beyond;
         s1_frac_ff  <= frac;
         s1_fb_ff    <= fb_ff;
      end
      if (s2_move) begin
         s2_left_ff <= left_data;
         s2_prod_ff <= prod_full[47:0];
         s2_fb_ff   <= s1_fb_ff;
      end
      if (out_free) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- Assertions ----------------
   // A write item never enters the lookup stages.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == itl_pkg::OP_WRITE) |=> !s1_valid_ff)
      else $error("write item entered the lookup pipeline");

   // A lookup item always occupies stage 1 after acceptance.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == itl_pkg::OP_LOOKUP) |=> s1_valid_ff)
      else $error("accepted lookup item was lost");

   // Any empty stage keeps the request side open.
   assert property (@(posedge clock) disable iff (reset)
      (!s1_valid_ff || !s2_valid_ff || !rsp_valid_ff) |-> req_tready)
      else $error("request stalled with an empty stage");

   // A clamped lookup carries no interpolation term.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_clamp_ff && s2_move) |=> (s2_prod_ff == '0))
      else $error("clamped lookup produced a nonzero product");

endmodule

// ===== hw/rtl/itl_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ---------------------------------------------------------------------------
module itl_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 128,
   localparam int unsigned AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sim/interpolated_table_lookup_top_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Interpolated table lookup: self-checking testbench
// The table is loaded in full, then write and lookup items are sent under
// several fraction-width and table-length settings. A behavioral predictor
// keeps its own copy of the table and computes every lookup result, which
// the monitor compares with the block's output in order.
// ---------------------------------------------------------------------------
module interpolated_table_lookup_top_tb;

   typedef struct {
      logic               op;
      logic [6:0]         slot;
      logic signed [31:0] entry;
      logic signed [31:0] position;
   } request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   // Predictor state: table contents and register settings as the block sees them.
   logic signed [31:0] entry_copy [128];
   logic [3:0]         frac_bits_cfg = itl_pkg::FRACTION_BITS_RESET;
   logic [7:0]         length_cfg = 8'(itl_pkg::TABLE_LENGTH_RESET);

   request_type        pending_items [$];
   logic signed [31:0] expected_values [$];
   request_type        in_flight;

   bit idle_on = 1'b1;
   int send_gap = 0;
   int recv_gap = 0;
   int hold_left = 0;
   int holds_asked = 0;
   int holds_done = 0;
   int mismatches = 0;
   int writes_done = 0;
   int lookups_done = 0;
   int results_checked = 0;
   int csr_writes = 0;

   interpolated_table_lookup_top #(
      .TABLE_DEPTH(128)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Highest slot in use; the programmed length saturates into 2..128.
   function automatic int unsigned last_slot();
      if (length_cfg < 2) return 1;
      if (length_cfg > 128) return 127;
      return length_cfg - 1;
   endfunction

   function automatic logic signed [31:0] interpolate(input logic signed [31:0] pos);
      longint      span, offset, left, right, prod, step;
      int unsigned base;
      span = longint'(last_slot()) << frac_bits_cfg;
      if (pos < 0) return entry_copy[0];
      if (longint'(pos) >= span) return entry_copy[last_slot()];
      base = int'(pos) >> frac_bits_cfg;
      offset = longint'(pos) & ((longint'(1) << frac_bits_cfg) - 1);
      left = entry_copy[base];
      right = entry_copy[base + 1];
      prod = (right - left) * offset;
      // The scaled step is truncated toward zero, not floored.
      step = (prod < 0) ? -((-prod) >> frac_bits_cfg) : (prod >> frac_bits_cfg);
      return 32'(left + step);
   endfunction

   function automatic logic signed [31:0] pick_entry();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 2000) - 1000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [31:0] pick_position();
      int unsigned span;
      span = last_slot() << frac_bits_cfg;
      case ($urandom_range(0, 9))
         0: return $urandom | 32'h8000_0000;
         1: return $urandom;
         2: return span + $urandom_range(0, 2) - 1;
         default: return $urandom_range(0, span - 1);
      endcase
   endfunction

   task automatic queue_write(input logic [6:0] slot, input logic signed [31:0] entry);
      request_type r;
      r.op = itl_pkg::OP_WRITE;
      r.slot = slot;
      r.entry = entry;
      r.position = $urandom;
      pending_items.push_back(r);
   endtask

   task automatic queue_lookup(input logic signed [31:0] position);
      request_type r;
      r.op = itl_pkg::OP_LOOKUP;
      r.slot = 7'($urandom);
      r.entry = $urandom;
      r.position = position;
      pending_items.push_back(r);
   endtask

   // Random mix of writes and lookups; writes mostly land in the slots in use.
   task automatic queue_mix(input int count, input int write_pct);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < write_pct) begin
            if ($urandom_range(0, 7) == 0) queue_write(7'($urandom_range(0, 127)), pick_entry());
            else queue_write(7'($urandom_range(0, last_slot())), pick_entry());
         end else begin
            queue_lookup(pick_position());
         end
      end
   endtask

   // Returns once no item is pending or being driven and no result is still expected.
   task automatic wait_idle();
      int quiet;
      quiet = 0;
      while (quiet < 8) begin
         @(posedge clock);
         if (pending_items.size() != 0 || req_tvalid || expected_values.size() != 0) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
   endtask

   task automatic write_csr(input logic [0:0] which, input logic [7:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (which == itl_pkg::CSR_FRACTION_BITS) begin
         frac_bits_cfg = data[3:0];
      end else begin
         length_cfg = data;
      end
      csr_writes++;
   endtask

   // Request driver: predicts each item as it is accepted, then loads the next.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (in_flight.op == itl_pkg::OP_LOOKUP) begin
               expected_values.push_back(interpolate(in_flight.position));
               lookups_done++;
            end else begin
               entry_copy[in_flight.slot] = in_flight.entry;
               writes_done++;
            end
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               in_flight = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= in_flight.op;
               req_tdata <= {1'b0, in_flight.position, in_flight.entry, in_flight.slot};
               if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 13);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result ready: random stalls, plus a long hold-off whenever one is asked for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap = 0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (holds_done != holds_asked) begin
         holds_done++;
         hold_left = 80;
         rsp_tready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (idle_on && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 13);
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_values.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("%0t: unexpected result %h", $realtime, rsp_tdata);
         end else if (rsp_tdata !== expected_values[0]) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: value mismatch, expected %h, got %h",
                        $realtime, expected_values[0], rsp_tdata);
            end
            void'(expected_values.pop_front());
            results_checked++;
         end else begin
            void'(expected_values.pop_front());
            results_checked++;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: 14 fraction bits, 65 entries. Every slot is loaded first
      // so that no lookup can touch an unwritten entry.
      for (int s = 0; s < 128; s++) queue_write(7'(s), pick_entry());
      queue_write(7'd0, 32'h8000_0000);
      queue_write(7'd1, 32'h7FFF_FFFF);
      queue_lookup((1 << 14) - 1);            // full span times the largest fraction
      queue_lookup(0);
      queue_lookup(-1);
      queue_lookup(32'h8000_0000);
      queue_lookup(32'h7FFF_FFFF);
      queue_lookup(64 << 14);                 // exactly at the last entry
      queue_lookup((64 << 14) - 1);
      queue_write(7'd2, 32'h8000_0000);
      queue_lookup((1 << 14) + 1);            // most negative slope, tiny fraction
      queue_lookup((1 << 14) | (1 << 13));
      queue_write(7'd64, 32'h7FFF_FFFF);
      queue_lookup(64 << 14);                 // read right after a write of the same slot
      queue_write(7'd127, -1);
      queue_write(7'd10, 100);
      queue_write(7'd11, 103);
      queue_lookup((10 << 14) + 1);
      queue_write(7'd11, 97);
      queue_lookup((11 << 14) - 1);           // negative step must round toward zero
      queue_mix(30, 30);
      wait_idle();

      // No fraction bits and the shortest table.
      write_csr(itl_pkg::CSR_FRACTION_BITS, 8'd0);
      write_csr(itl_pkg::CSR_TABLE_LENGTH, 8'd2);
      queue_mix(40, 30);
      wait_idle();

      // Widest fraction and full table, with a long result stall up front.
      write_csr(itl_pkg::CSR_FRACTION_BITS, 8'd15);
      write_csr(itl_pkg::CSR_TABLE_LENGTH, 8'd128);
      @(posedge clock);
      holds_asked <= holds_asked + 1;
      queue_mix(50, 10);
      wait_idle();

      // Upper data bits are ignored by the fraction register; the length saturates.
      @(posedge clock);
      idle_on <= 1'b0;
      write_csr(itl_pkg::CSR_FRACTION_BITS, 8'hFA);
      write_csr(itl_pkg::CSR_TABLE_LENGTH, 8'd255);
      queue_mix(40, 30);
      wait_idle();

      @(posedge clock);
      idle_on <= 1'b1;
      write_csr(itl_pkg::CSR_FRACTION_BITS, 8'd12);
      write_csr(itl_pkg::CSR_TABLE_LENGTH, 8'd1);
      queue_mix(30, 30);
      wait_idle();

      for (int p = 0; p < 2; p++) begin
         write_csr(itl_pkg::CSR_FRACTION_BITS, 8'($urandom_range(0, 255)));
         write_csr(itl_pkg::CSR_TABLE_LENGTH, 8'($urandom_range(0, 255)));
         queue_mix(25, 30);
         wait_idle();
      end

      // Back to the reset settings at full rate on both sides.
      @(posedge clock);
      idle_on <= 1'b0;
      write_csr(itl_pkg::CSR_FRACTION_BITS, 8'd14);
      write_csr(itl_pkg::CSR_TABLE_LENGTH, 8'd65);
      queue_mix(30, 30);
      wait_idle();

      $display("Sent %0d table writes and %0d lookups over %0d register writes.",
               writes_done, lookups_done, csr_writes);
      $display("Compared %0d results, %0d mismatched.", results_checked, mismatches);
      if (mismatches == 0 && expected_values.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d results outstanding.", expected_values.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
